// ===== hdl/ufsef_pkg.sv =====
// Shared types, constants and the control program of the spanning edge filter.
package ufsef_pkg;

   localparam int DEF_MAX_NODES     = 1024;
   localparam int DEF_WEIGHT_WIDTH  = 16;
   localparam int NODE_WIDTH        = 10;
   localparam int NODE_COUNT_WIDTH  = 11;
   localparam int EDGE_WEIGHT_WIDTH = 16;
   localparam int SUM_WIDTH         = 32;
   localparam int COUNT_WIDTH       = 10;
   localparam int RANK_WIDTH        = 4;
   localparam int CSR_INDEX_WIDTH   = 1;
   localparam int STEP_WIDTH        = 5;

   localparam logic [NODE_COUNT_WIDTH-1:0] NODE_COUNT_RESET = 11'd1024;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NODE_COUNT = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNION_RULE = 1'b1;

   typedef logic [STEP_WIDTH-1:0] step_type;

   localparam step_type S_CLEAR    = 5'd0;
   localparam step_type S_RESUME   = 5'd1;
   localparam step_type S_IDLE     = 5'd2;
   localparam step_type S_START    = 5'd3;
   localparam step_type S_CHECK    = 5'd4;
   localparam step_type S_FA_READ  = 5'd5;
   localparam step_type S_FA_TEST  = 5'd6;
   localparam step_type S_FA_ROOT  = 5'd7;
   localparam step_type S_CA_READ  = 5'd8;
   localparam step_type S_CA_WRITE = 5'd9;
   localparam step_type S_CA_DONE  = 5'd10;
   localparam step_type S_FB_READ  = 5'd11;
   localparam step_type S_FB_TEST  = 5'd12;
   localparam step_type S_FB_ROOT  = 5'd13;
   localparam step_type S_CB_READ  = 5'd14;
   localparam step_type S_CB_WRITE = 5'd15;
   localparam step_type S_CB_DONE  = 5'd16;
   localparam step_type S_READ_A   = 5'd17;
   localparam step_type S_READ_B   = 5'd18;
   localparam step_type S_MERGE    = 5'd19;
   localparam step_type S_LINK     = 5'd20;
   localparam step_type S_WAIT     = 5'd21;
   localparam step_type S_EMIT     = 5'd22;

   typedef enum logic [2:0] {
      ADDR_CUR,
      ADDR_RA,
      ADDR_RB,
      ADDR_TOP,
      ADDR_CHILD,
      ADDR_CLR
   } addr_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_CLEAR,
      WR_LINK_ROOT,
      WR_MERGE,
      WR_LINK_CHILD
   } wr_sel_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_CLEAR,
      OP_CAPTURE,
      OP_LOAD_A,
      OP_FOLLOW,
      OP_ROOT_A,
      OP_ROOT_B,
      OP_SAVE_A,
      OP_SAVE_B,
      OP_LATCH_A,
      OP_MERGE,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_CLR_MORE,
      C_JOB,
      C_NO_REQ,
      C_START,
      C_BAD,
      C_PAR_NE_CUR,
      C_CUR_EQ_ROOT,
      C_RA_EQ_ROOT,
      C_RSP_BUSY
   } cond_type;

   typedef struct packed {
      logic         take;
      addr_sel_type addr_sel;
      wr_sel_type   wr_sel;
      op_type       op;
      cond_type     cond;
      step_type     target;
   } ctrl_word_type;

   typedef struct packed {
      logic clr_more;
      logic job;
      logic no_req;
      logic start;
      logic bad;
      logic par_ne_cur;
      logic cur_eq_root;
      logic ra_eq_root;
      logic rsp_busy;
   } flags_type;

   function automatic ctrl_word_type ucode_word(input step_type step);
      ctrl_word_type word;
      word = '{1'b0, ADDR_CUR, WR_NONE, OP_NONE, C_NEVER, S_IDLE};
      case (step)
         S_CLEAR:    word = '{1'b0, ADDR_CLR, WR_CLEAR, OP_CLEAR, C_CLR_MORE, S_CLEAR};
         S_RESUME:   word = '{1'b0, ADDR_CUR, WR_NONE, OP_NONE, C_JOB, S_CHECK};
         S_IDLE:     word = '{1'b1, ADDR_CUR, WR_NONE, OP_CAPTURE, C_NO_REQ, S_IDLE};
         S_START:    word = '{1'b0, ADDR_CUR, WR_NONE, OP_LOAD_A, C_START, S_CLEAR};
         S_CHECK:    word = '{1'b0, ADDR_CUR, WR_NONE, OP_NONE, C_BAD, S_WAIT};
         S_FA_READ:  word = '{1'b0, ADDR_CUR, WR_NONE, OP_NONE, C_NEVER, S_IDLE};
         S_FA_TEST:  word = '{1'b0, ADDR_CUR, WR_NONE, OP_FOLLOW, C_PAR_NE_CUR, S_FA_READ};
         S_FA_ROOT:  word = '{1'b0, ADDR_CUR, WR_NONE, OP_ROOT_A, C_NEVER, S_IDLE};
         S_CA_READ:  word = '{1'b0, ADDR_CUR, WR_NONE, OP_NONE, C_CUR_EQ_ROOT, S_CA_DONE};
         S_CA_WRITE: word = '{1'b0, ADDR_CUR, WR_LINK_ROOT, OP_FOLLOW, C_ALWAYS, S_CA_READ};
         S_CA_DONE:  word = '{1'b0, ADDR_CUR, WR_NONE, OP_SAVE_A, C_NEVER, S_IDLE};
         S_FB_READ:  word = '{1'b0, ADDR_CUR, WR_NONE, OP_NONE, C_NEVER, S_IDLE};
         S_FB_TEST:  word = '{1'b0, ADDR_CUR, WR_NONE, OP_FOLLOW, C_PAR_NE_CUR, S_FB_READ};
         S_FB_ROOT:  word = '{1'b0, ADDR_CUR, WR_NONE, OP_ROOT_B, C_NEVER, S_IDLE};
         S_CB_READ:  word = '{1'b0, ADDR_CUR, WR_NONE, OP_NONE, C_CUR_EQ_ROOT, S_CB_DONE};
         S_CB_WRITE: word = '{1'b0, ADDR_CUR, WR_LINK_ROOT, OP_FOLLOW, C_ALWAYS, S_CB_READ};
         S_CB_DONE:  word = '{1'b0, ADDR_CUR, WR_NONE, OP_SAVE_B, C_RA_EQ_ROOT, S_WAIT};
         S_READ_A:   word = '{1'b0, ADDR_RA, WR_NONE, OP_NONE, C_NEVER, S_IDLE};
         S_READ_B:   word = '{1'b0, ADDR_RB, WR_NONE, OP_LATCH_A, C_NEVER, S_IDLE};
         S_MERGE:    word = '{1'b0, ADDR_TOP, WR_MERGE, OP_MERGE, C_NEVER, S_IDLE};
         S_LINK:     word = '{1'b0, ADDR_CHILD, WR_LINK_CHILD, OP_NONE, C_NEVER, S_IDLE};
         S_WAIT:     word = '{1'b0, ADDR_CUR, WR_NONE, OP_NONE, C_RSP_BUSY, S_WAIT};
         S_EMIT:     word = '{1'b0, ADDR_CUR, WR_NONE, OP_EMIT, C_ALWAYS, S_IDLE};
         default:    word = '{1'b0, ADDR_CUR, WR_NONE, OP_NONE, C_ALWAYS, S_IDLE};
      endcase
      return word;
   endfunction

endpackage

// ===== hdl/ufsef_forest_mem.sv =====
// Parent, set size and rank memories of the disjoint-set forest.
module ufsef_forest_mem #(
   parameter int MAX_NODES = ufsef_pkg::DEF_MAX_NODES
) (
   input  logic                                 clock,
   input  logic [$clog2(MAX_NODES)-1:0]         addr,
   input  logic                                 we_parent,
   input  logic                                 we_size,
   input  logic                                 we_rank,
   input  logic [$clog2(MAX_NODES)-1:0]         wr_parent,
   input  logic [$clog2(MAX_NODES+1)-1:0]       wr_size,
   input  logic [ufsef_pkg::RANK_WIDTH-1:0]     wr_rank,
   output logic [$clog2(MAX_NODES)-1:0]         rd_parent,
   output logic [$clog2(MAX_NODES+1)-1:0]       rd_size,
   output logic [ufsef_pkg::RANK_WIDTH-1:0]     rd_rank
);
   import ufsef_pkg::*;

   localparam int NW = $clog2(MAX_NODES);
   localparam int SW = $clog2(MAX_NODES+1);

   logic [NW-1:0]         parent_mem_ff [MAX_NODES];
   logic [SW-1:0]         size_mem_ff   [MAX_NODES];
   logic [RANK_WIDTH-1:0] rank_mem_ff   [MAX_NODES];
   logic [NW-1:0]         rd_parent_ff;
   logic [SW-1:0]         rd_size_ff;
   logic [RANK_WIDTH-1:0] rd_rank_ff;

   always_ff @(posedge clock) begin
      if (we_parent) begin
         parent_mem_ff[addr] <= wr_parent;
      end
      rd_parent_ff <= parent_mem_ff[addr];
   end

   always_ff @(posedge clock) begin
      if (we_size) begin
         size_mem_ff[addr] <= wr_size;
      end
      rd_size_ff <= size_mem_ff[addr];
   end

   always_ff @(posedge clock) begin
      if (we_rank) begin
         rank_mem_ff[addr] <= wr_rank;
      end
      rd_rank_ff <= rank_mem_ff[addr];
   end

   assign rd_parent = rd_parent_ff;
   assign rd_size   = rd_size_ff;
   assign rd_rank   = rd_rank_ff;

endmodule

// ===== hdl/ufsef_sequencer.sv =====
// Step counter and control store that drive the filter datapath.
module ufsef_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  ufsef_pkg::flags_type     flags,
   output ufsef_pkg::ctrl_word_type ctrl
);
   import ufsef_pkg::*;

   step_type      upc_ff;
   step_type      upc_in;
   ctrl_word_type word;
   logic          jump;

   always_comb begin
      word = ucode_word(upc_ff);
      case (word.cond)
         C_NEVER:       jump = 1'b0;
         C_ALWAYS:      jump = 1'b1;
         C_CLR_MORE:    jump = flags.clr_more;
         C_JOB:         jump = flags.job;
         C_NO_REQ:      jump = flags.no_req;
         C_START:       jump = flags.start;
         C_BAD:         jump = flags.bad;
         C_PAR_NE_CUR:  jump = flags.par_ne_cur;
         C_CUR_EQ_ROOT: jump = flags.cur_eq_root;
         C_RA_EQ_ROOT:  jump = flags.ra_eq_root;
         C_RSP_BUSY:    jump = flags.rsp_busy;
         default:       jump = 1'b0;
      endcase
      upc_in = jump ? word.target : step_type'(upc_ff + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctrl = word;

endmodule

// ===== hdl/ufsef_datapath.sv =====
// Node registers, merge logic, totals and result register of the filter.
module ufsef_datapath #(
   parameter int MAX_NODES    = ufsef_pkg::DEF_MAX_NODES,
   parameter int WEIGHT_WIDTH = ufsef_pkg::DEF_WEIGHT_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  ufsef_pkg::ctrl_word_type               ctrl,
   output ufsef_pkg::flags_type                   flags,
   input  logic [ufsef_pkg::NODE_COUNT_WIDTH-1:0] node_count,
   input  logic                                   union_rule,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_start_new,
   input  logic [ufsef_pkg::NODE_WIDTH-1:0]       req_node_a,
   input  logic [ufsef_pkg::NODE_WIDTH-1:0]       req_node_b,
   input  logic [ufsef_pkg::EDGE_WEIGHT_WIDTH-1:0] req_edge_weight,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_accepted,
   output logic                                   rsp_bad_node,
   output logic [ufsef_pkg::SUM_WIDTH-1:0]        rsp_total_weight,
   output logic [ufsef_pkg::COUNT_WIDTH-1:0]      rsp_tree_edges,
   output logic [$clog2(MAX_NODES)-1:0]           mem_addr,
   output logic                                   mem_we_parent,
   output logic                                   mem_we_size,
   output logic                                   mem_we_rank,
   output logic [$clog2(MAX_NODES)-1:0]           mem_wr_parent,
   output logic [$clog2(MAX_NODES+1)-1:0]         mem_wr_size,
   output logic [ufsef_pkg::RANK_WIDTH-1:0]       mem_wr_rank,
   input  logic [$clog2(MAX_NODES)-1:0]           mem_rd_parent,
   input  logic [$clog2(MAX_NODES+1)-1:0]         mem_rd_size,
   input  logic [ufsef_pkg::RANK_WIDTH-1:0]       mem_rd_rank
);
   import ufsef_pkg::*;

   localparam int NW = $clog2(MAX_NODES);
   localparam int SW = $clog2(MAX_NODES+1);
   localparam int LW = (SW > NODE_COUNT_WIDTH) ? SW : NODE_COUNT_WIDTH;
   localparam int EW = (WEIGHT_WIDTH < EDGE_WEIGHT_WIDTH) ? WEIGHT_WIDTH : EDGE_WEIGHT_WIDTH;

   logic [NW-1:0]          clr_ff, clr_in;
   logic                   job_ff, job_in;
   logic                   start_ff, start_in;
   logic [NODE_WIDTH-1:0]  a_ff, a_in;
   logic [NODE_WIDTH-1:0]  b_ff, b_in;
   logic [EW-1:0]          w_ff, w_in;
   logic [NW-1:0]          cur_ff, cur_in;
   logic [NW-1:0]          root_ff, root_in;
   logic [NW-1:0]          ra_ff, ra_in;
   logic [NW-1:0]          rb_ff, rb_in;
   logic [NW-1:0]          child_ff, child_in;
   logic [NW-1:0]          top_ff, top_in;
   logic [SW-1:0]          size_a_ff, size_a_in;
   logic [RANK_WIDTH-1:0]  rank_a_ff, rank_a_in;
   logic                   acc_ff, acc_in;
   logic [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_acc_ff, rsp_acc_in;
   logic                   rsp_bad_ff, rsp_bad_in;
   logic [SUM_WIDTH-1:0]   rsp_sum_ff, rsp_sum_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff, rsp_count_in;

   logic [LW-1:0]          limit;
   logic                   bad;
   logic                   clr_last;
   logic                   rsp_busy;
   logic                   swap;
   logic [NW-1:0]          child_pick, top_pick;
   logic [RANK_WIDTH-1:0]  rank_child, rank_top, rank_new;
   logic [SW-1:0]          size_new;
   logic [SUM_WIDTH:0]     sum_wide;
   logic [SUM_WIDTH-1:0]   sum_next;
   logic [COUNT_WIDTH-1:0] count_next;

   always_comb begin
      limit = (LW'(node_count) > LW'(MAX_NODES)) ? LW'(MAX_NODES) : LW'(node_count);
      bad = (LW'(a_ff) >= limit) || (LW'(b_ff) >= limit);
      clr_last = (clr_ff == NW'(MAX_NODES - 1));
      rsp_busy = rsp_valid_ff && rsp_stall;

      swap = union_rule ? (rank_a_ff < mem_rd_rank) : (size_a_ff < mem_rd_size);
      child_pick = swap ? ra_ff : rb_ff;
      top_pick   = swap ? rb_ff : ra_ff;
      rank_child = swap ? rank_a_ff : mem_rd_rank;
      rank_top   = swap ? mem_rd_rank : rank_a_ff;
      rank_new   = (rank_top > rank_child) ? rank_top : rank_child;
      if ((rank_top == rank_child) && (rank_new != '1)) begin
         rank_new = rank_new + 1'b1;
      end
      size_new = size_a_ff + mem_rd_size;

      sum_wide   = {1'b0, sum_ff} + (SUM_WIDTH+1)'(w_ff);
      sum_next   = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
      count_next = (count_ff == '1) ? count_ff : count_ff + 1'b1;
   end

   always_comb begin
      flags.clr_more    = !clr_last;
      flags.job         = job_ff;
      flags.no_req      = !req_valid;
      flags.start       = start_ff;
      flags.bad         = bad;
      flags.par_ne_cur  = (mem_rd_parent != cur_ff);
      flags.cur_eq_root = (cur_ff == root_ff);
      flags.ra_eq_root  = (ra_ff == root_ff);
      flags.rsp_busy    = rsp_busy;
   end

   always_comb begin
      case (ctrl.addr_sel)
         ADDR_CUR:   mem_addr = cur_ff;
         ADDR_RA:    mem_addr = ra_ff;
         ADDR_RB:    mem_addr = rb_ff;
         ADDR_TOP:   mem_addr = top_pick;
         ADDR_CHILD: mem_addr = child_ff;
         ADDR_CLR:   mem_addr = clr_ff;
         default:    mem_addr = cur_ff;
      endcase
      mem_we_parent = 1'b0;
      mem_we_size   = 1'b0;
      mem_we_rank   = 1'b0;
      mem_wr_parent = root_ff;
      mem_wr_size   = size_new;
      mem_wr_rank   = rank_new;
      case (ctrl.wr_sel)
         WR_CLEAR: begin
            mem_we_parent = 1'b1;
            mem_we_size   = 1'b1;
            mem_we_rank   = 1'b1;
            mem_wr_parent = clr_ff;
            mem_wr_size   = SW'(1);
            mem_wr_rank   = '0;
         end
         WR_LINK_ROOT: begin
            mem_we_parent = 1'b1;
         end
         WR_MERGE: begin
            mem_we_size = 1'b1;
            mem_we_rank = 1'b1;
         end
         WR_LINK_CHILD: begin
            mem_we_parent = 1'b1;
            mem_wr_parent = top_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      clr_in       = clr_ff;
      job_in       = job_ff;
      start_in     = start_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      w_in         = w_ff;
      cur_in       = cur_ff;
      root_in      = root_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      child_in     = child_ff;
      top_in       = top_ff;
      size_a_in    = size_a_ff;
      rank_a_in    = rank_a_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_bad_in   = rsp_bad_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_busy;
      case (ctrl.op)
         OP_CLEAR: begin
            clr_in   = clr_last ? '0 : clr_ff + 1'b1;
            sum_in   = '0;
            count_in = '0;
         end
         OP_CAPTURE: begin
            if (req_valid) begin
               job_in   = 1'b1;
               start_in = req_start_new;
               a_in     = req_node_a;
               b_in     = req_node_b;
               w_in     = req_edge_weight[EW-1:0];
               acc_in   = 1'b0;
            end
         end
         OP_LOAD_A: begin
            cur_in = NW'(a_ff);
         end
         OP_FOLLOW: begin
            cur_in = mem_rd_parent;
         end
         OP_ROOT_A: begin
            root_in = cur_ff;
            cur_in  = NW'(a_ff);
         end
         OP_ROOT_B: begin
            root_in = cur_ff;
            cur_in  = NW'(b_ff);
         end
         OP_SAVE_A: begin
            ra_in  = root_ff;
            cur_in = NW'(b_ff);
         end
         OP_SAVE_B: begin
            rb_in = root_ff;
         end
         OP_LATCH_A: begin
            size_a_in = mem_rd_size;
            rank_a_in = mem_rd_rank;
         end
         OP_MERGE: begin
            child_in = child_pick;
            top_in   = top_pick;
            acc_in   = 1'b1;
            sum_in   = sum_next;
            count_in = count_next;
         end
         OP_EMIT: begin
            job_in       = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_acc_in   = acc_ff;
            rsp_bad_in   = bad;
            rsp_sum_in   = sum_ff;
            rsp_count_in = count_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         job_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         job_ff       <= job_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      w_ff         <= w_in;
      cur_ff       <= cur_in;
      root_ff      <= root_in;
      ra_ff        <= ra_in;
      rb_ff        <= rb_in;
      child_ff     <= child_in;
      top_ff       <= top_in;
      size_a_ff    <= size_a_in;
      rank_a_ff    <= rank_a_in;
      acc_ff       <= acc_in;
      sum_ff       <= sum_in;
      count_ff     <= count_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_bad_ff   <= rsp_bad_in;
      rsp_sum_ff   <= rsp_sum_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_stall        = !ctrl.take;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_bad_node     = rsp_bad_ff;
   assign rsp_total_weight = rsp_sum_ff;
   assign rsp_tree_edges   = rsp_count_ff;

endmodule

// ===== hdl/union_find_spanning_edge_filter_top.sv =====
// Top level of the spanning tree edge filter over a disjoint-set forest.
//
// Each request item carries one graph edge: two node numbers, a weight and a
// start flag. Edges must arrive in ascending weight order. Each item yields
// exactly one response item with the accept and bad-node flags, the running
// saturated weight total and the number of tree edges so far.
// The csr port writes the node count and the union rule; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// A control program steps a single-port forest memory: each link followed or
// rewritten takes a read step and then a test or write step. The response
// turns valid in the cycle the input opens again. An edge with a bad endpoint
// skips the forest walk and goes straight to the response steps.
// A start flag first runs a clearing pass over all MAX_NODES forest entries.
// After reset the same clearing pass runs before the first item is taken;
// configuration writes are taken during it.
// A finished response waits in an output register while the receiver stalls,
// and the next request item can be taken meanwhile; its own response then
// waits until the register is free.
module union_find_spanning_edge_filter_top #(
   parameter int MAX_NODES    = ufsef_pkg::DEF_MAX_NODES,
   parameter int WEIGHT_WIDTH = ufsef_pkg::DEF_WEIGHT_WIDTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [ufsef_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [ufsef_pkg::NODE_COUNT_WIDTH-1:0]  csr_write_data,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_start_new,
   input  logic [ufsef_pkg::NODE_WIDTH-1:0]        req_node_a,
   input  logic [ufsef_pkg::NODE_WIDTH-1:0]        req_node_b,
   input  logic [ufsef_pkg::EDGE_WEIGHT_WIDTH-1:0] req_edge_weight,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_accepted,
   output logic                                    rsp_bad_node,
   output logic [ufsef_pkg::SUM_WIDTH-1:0]         rsp_total_weight,
   output logic [ufsef_pkg::COUNT_WIDTH-1:0]       rsp_tree_edges
);
   import ufsef_pkg::*;

   localparam int NW = $clog2(MAX_NODES);
   localparam int SW = $clog2(MAX_NODES+1);

   logic [NODE_COUNT_WIDTH-1:0] node_count_ff, node_count_in;
   logic                        union_rule_ff, union_rule_in;

   ctrl_word_type         ctrl;
   flags_type             flags;
   logic [NW-1:0]         mem_addr;
   logic                  mem_we_parent;
   logic                  mem_we_size;
   logic                  mem_we_rank;
   logic [NW-1:0]         mem_wr_parent;
   logic [SW-1:0]         mem_wr_size;
   logic [RANK_WIDTH-1:0] mem_wr_rank;
   logic [NW-1:0]         mem_rd_parent;
   logic [SW-1:0]         mem_rd_size;
   logic [RANK_WIDTH-1:0] mem_rd_rank;

   always_comb begin
      node_count_in = node_count_ff;
      union_rule_in = union_rule_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_NODE_COUNT: node_count_in = csr_write_data;
            CSR_UNION_RULE: union_rule_in = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
         union_rule_ff <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         union_rule_ff <= union_rule_in;
      end
   end

   ufsef_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   ufsef_datapath #(
      .MAX_NODES    (MAX_NODES),
      .WEIGHT_WIDTH (WEIGHT_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .flags            (flags),
      .node_count       (node_count_ff),
      .union_rule       (union_rule_ff),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_start_new    (req_start_new),
      .req_node_a       (req_node_a),
      .req_node_b       (req_node_b),
      .req_edge_weight  (req_edge_weight),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_bad_node     (rsp_bad_node),
      .rsp_total_weight (rsp_total_weight),
      .rsp_tree_edges   (rsp_tree_edges),
      .mem_addr         (mem_addr),
      .mem_we_parent    (mem_we_parent),
      .mem_we_size      (mem_we_size),
      .mem_we_rank      (mem_we_rank),
      .mem_wr_parent    (mem_wr_parent),
      .mem_wr_size      (mem_wr_size),
      .mem_wr_rank      (mem_wr_rank),
      .mem_rd_parent    (mem_rd_parent),
      .mem_rd_size      (mem_rd_size),
      .mem_rd_rank      (mem_rd_rank)
   );

   ufsef_forest_mem #(
      .MAX_NODES (MAX_NODES)
   ) u_forest_mem (
      .clock     (clock),
      .addr      (mem_addr),
      .we_parent (mem_we_parent),
      .we_size   (mem_we_size),
      .we_rank   (mem_we_rank),
      .wr_parent (mem_wr_parent),
      .wr_size   (mem_wr_size),
      .wr_rank   (mem_wr_rank),
      .rd_parent (mem_rd_parent),
      .rd_size   (mem_rd_size),
      .rd_rank   (mem_rd_rank)
   );

endmodule
